/* rtl/core/mctc_pkg.sv */
// shared types and constants of the multi-channel trace capture core
`timescale 1ns / 1ps
`default_nettype none

package mctc_pkg;

  // default sample store depth in 16-bit words
  localparam int STORE_DEPTH_DEF = 1024;
  // widest store address that any depth in range needs
  localparam int ADDR_W = 16;
  // width of the pointer fields in a reply
  localparam int PTR_OUT_W = 11;
  // jobs held between front and back
  localparam int QUEUE_DEPTH = 2;
  // words returned by one read
  localparam int READ_WORDS = 6;

  localparam logic [3:0] LEN_READ  = 4'd13;
  localparam logic [3:0] LEN_OTHER = 4'd5;

  typedef enum logic [2:0] {
    FUNC_TICK  = 3'd0,
    FUNC_ARM   = 3'd1,
    FUNC_QUERY = 3'd2,
    FUNC_READ  = 3'd3,
    FUNC_STOP  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    JOB_REPLY = 2'd0,
    JOB_WRITE = 2'd1,
    JOB_READ  = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  channel_count;
    logic [15:0] sample_a;
    logic [15:0] sample_b;
    logic [15:0] sample_c;
    logic [15:0] read_offset;
    logic [1:0]  read_bank;
  } cmd_t;

  typedef struct packed {
    logic                 accepted;
    logic [3:0]           reply_length;
    logic [PTR_OUT_W-1:0] first_pointer;
    logic [PTR_OUT_W-1:0] segment_words;
    logic [15:0]          word_0;
    logic [15:0]          word_1;
    logic [15:0]          word_2;
    logic [15:0]          word_3;
    logic [15:0]          word_4;
    logic [15:0]          word_5;
  } result_t;

  // one classified command on its way to the memory side
  typedef struct packed {
    job_kind_t                 kind;
    logic                      accepted;
    logic [PTR_OUT_W-1:0]      first_pointer;
    logic [PTR_OUT_W-1:0]      segment_words;
    logic [2:0]                wr_en;
    logic [2:0][ADDR_W-1:0]    wr_addr;
    logic [2:0][15:0]          wr_data;
    logic [15:0]               rd_start;
  } job_t;

endpackage

`default_nettype wire

/* rtl/core/mctc_front.sv */
// command front end: accepts, classifies and keeps the channel pointers
`timescale 1ns / 1ps
`default_nettype none

module mctc_front #(
  parameter int STORE_DEPTH = mctc_pkg::STORE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire mctc_pkg::cmd_t cmd,
  input  wire logic           q_full,
  input  wire logic           mem_ready,
  input  wire logic           cfg_valid,
  input  wire logic [15:0]    cfg_data,
  output logic                busy,
  output logic                push,
  output mctc_pkg::job_t      job
);

  localparam int PW = $clog2(STORE_DEPTH + 1);
  localparam logic [PW-1:0] DEPTH_P    = PW'(STORE_DEPTH);
  localparam logic [PW-1:0] HALF       = PW'(STORE_DEPTH / 2);
  localparam logic [PW-1:0] THIRD      = PW'(STORE_DEPTH / 3);
  localparam logic [PW-1:0] TWO_THIRDS = PW'((2 * STORE_DEPTH) / 3);

  logic [2:0][PW-1:0] wp, wp_next;
  logic [2:0][PW-1:0] ep, ep_next;
  logic [PW-1:0]      seg, seg_next;
  logic [15:0]        skip, skip_next;
  logic [15:0]        divider;
  logic [PW+1:0]      bank_prod;
  logic [15:0]        rd_start_addr;

  assign busy = !mem_ready || q_full;
  assign push = start && !busy;

  // start address folds to 16 bits
  assign bank_prod     = {{PW{1'b0}}, cmd.read_bank} * {2'b00, seg};
  assign rd_start_addr = cmd.read_offset + 16'(bank_prod);

  always_comb begin
    job          = '0;
    job.kind     = mctc_pkg::JOB_REPLY;
    job.accepted = 1'b1;
    job.wr_data[0] = cmd.sample_a;
    job.wr_data[1] = cmd.sample_b;
    job.wr_data[2] = cmd.sample_c;
    wp_next   = wp;
    ep_next   = ep;
    seg_next  = seg;
    skip_next = skip;
    case (cmd.func)
      mctc_pkg::FUNC_TICK: begin
        if (skip >= divider) begin
          skip_next = '0;
          job.kind  = mctc_pkg::JOB_WRITE;
          for (int k = 0; k < 3; k++) begin
            if (wp[k] < ep[k] && wp[k] < DEPTH_P) begin
              job.wr_en[k]   = 1'b1;
              job.wr_addr[k] = mctc_pkg::ADDR_W'(wp[k]);
              wp_next[k]     = wp[k] + PW'(1);
            end
          end
        end else begin
          skip_next = skip + 16'd1;
        end
      end
      mctc_pkg::FUNC_ARM: begin
        case (cmd.channel_count)
          2'd1: begin
            seg_next   = DEPTH_P;
            wp_next[0] = '0;
            wp_next[1] = DEPTH_P;
            wp_next[2] = DEPTH_P;
            ep_next[0] = DEPTH_P;
          end
          2'd2: begin
            seg_next   = HALF;
            wp_next[0] = '0;
            wp_next[1] = HALF;
            wp_next[2] = DEPTH_P;
            ep_next[0] = HALF;
            ep_next[1] = DEPTH_P;
          end
          2'd3: begin
            seg_next   = THIRD;
            wp_next[0] = '0;
            wp_next[1] = THIRD;
            wp_next[2] = TWO_THIRDS;
            ep_next[0] = THIRD;
            ep_next[1] = TWO_THIRDS;
            ep_next[2] = DEPTH_P;
          end
          default: begin
            // zero channels
            job.accepted = 1'b0;
          end
        endcase
      end
      mctc_pkg::FUNC_QUERY: begin
        job.first_pointer = mctc_pkg::PTR_OUT_W'(wp[0]);
        job.segment_words = mctc_pkg::PTR_OUT_W'(seg);
      end
      mctc_pkg::FUNC_READ: begin
        job.kind     = mctc_pkg::JOB_READ;
        job.rd_start = rd_start_addr;
      end
      mctc_pkg::FUNC_STOP: begin
        wp_next = {3{DEPTH_P}};
      end
      default: begin
        job.accepted = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= {3{DEPTH_P}};
      ep      <= {3{DEPTH_P}};
      seg     <= DEPTH_P;
      skip    <= '0;
      divider <= '0;
    end else begin
      if (push) begin
        wp   <= wp_next;
        ep   <= ep_next;
        seg  <= seg_next;
        skip <= skip_next;
      end
      if (cfg_valid) begin
        divider <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mctc_queue.sv */
// short job queue between the front end and the memory sequencer
`timescale 1ns / 1ps
`default_nettype none

module mctc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mctc_pkg::job_t push_job,
  input  wire logic           pop,
  output mctc_pkg::job_t      head,
  output logic                empty,
  output logic                full
);

  localparam int QD   = mctc_pkg::QUEUE_DEPTH;
  localparam int PTRW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNTW = $clog2(QD + 1);

  mctc_pkg::job_t slots [QD];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [CNTW-1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CNTW'(QD));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(QD - 1)) ? '0 : wr_ptr + PTRW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(QD - 1)) ? '0 : rd_ptr + PTRW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mctc_back.sv */
// memory sequencer: sample store, clearing pass, writes, reads and replies
`timescale 1ns / 1ps
`default_nettype none

module mctc_back #(
  parameter int STORE_DEPTH = mctc_pkg::STORE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mctc_pkg::job_t job,
  input  wire logic           empty,
  output logic                pop,
  output logic                mem_ready,
  output logic                done,
  output mctc_pkg::result_t   result
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int SW = $clog2(mctc_pkg::READ_WORDS + 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WRITE = 5'b00100,
    ST_READ  = 5'b01000,
    ST_REPLY = 5'b10000
  } state_t;

  state_t         state;
  logic [AW-1:0]  clr_addr;
  logic [SW-1:0]  step;
  mctc_pkg::job_t cur;
  logic [15:0]    words [mctc_pkg::READ_WORDS];
  logic [15:0]    mem [STORE_DEPTH];
  logic [15:0]    rd_data;
  logic           rd_hit;

  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  logic [15:0]    mem_wdata;
  logic [16:0]    rd_addr_full;
  logic           in_range;
  logic [1:0]     wr_idx;

  assign pop       = (state == ST_IDLE) && !empty;
  assign mem_ready = (state != ST_CLEAR);

  assign wr_idx       = step[1:0];
  assign rd_addr_full = {1'b0, cur.rd_start} + 17'(step);
  assign in_range     = (step < SW'(mctc_pkg::READ_WORDS)) &&
                        (rd_addr_full < 17'(STORE_DEPTH));

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = clr_addr;
    mem_wdata = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_WRITE: begin
        mem_we    = cur.wr_en[wr_idx];
        mem_addr  = cur.wr_addr[wr_idx][AW-1:0];
        mem_wdata = cur.wr_data[wr_idx];
      end
      ST_READ: begin
        mem_addr = rd_addr_full[AW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // single-port store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      step     <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          step <= '0;
          if (!empty) begin
            case (job.kind)
              mctc_pkg::JOB_WRITE: state <= ST_WRITE;
              mctc_pkg::JOB_READ:  state <= ST_READ;
              default:             state <= ST_REPLY;
            endcase
          end
        end
        ST_WRITE: begin
          step <= step + SW'(1);
          if (step == SW'(2)) begin
            state <= ST_REPLY;
          end
        end
        ST_READ: begin
          step <= step + SW'(1);
          if (step == SW'(mctc_pkg::READ_WORDS)) begin
            state <= ST_REPLY;
          end
        end
        ST_REPLY: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_hit <= in_range;
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          cur <= job;
          for (int k = 0; k < mctc_pkg::READ_WORDS; k++) begin
            words[k] <= '0;
          end
        end
      end
      ST_READ: begin
        if (step != '0) begin
          words[SW'(step - SW'(1))] <= rd_hit ? rd_data : 16'd0;
        end
      end
      ST_REPLY: begin
        result.accepted      <= cur.accepted;
        result.reply_length  <= (cur.kind == mctc_pkg::JOB_READ) ?
                                mctc_pkg::LEN_READ : mctc_pkg::LEN_OTHER;
        result.first_pointer <= cur.first_pointer;
        result.segment_words <= cur.segment_words;
        result.word_0        <= words[0];
        result.word_1        <= words[1];
        result.word_2        <= words[2];
        result.word_3        <= words[3];
        result.word_4        <= words[4];
        result.word_5        <= words[5];
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/multi_channel_trace_capture_core.sv */
// top level of the multi-channel trace capture core
`timescale 1ns / 1ps
`default_nettype none

// trace buffer with up to three capture channels in one shared sample store.
// a command is taken on a clock edge with start high and busy low; exactly one
// result beat follows per command, shown for a single cycle with done high.
// the receiver cannot hold results off, so it must take every beat as it
// comes. after reset the store is swept to zero, one word per cycle, with
// busy high (configuration writes are still taken). once a command has been
// taken it is classified in the front end and queued; the memory side goes
// straight to its reply state for query, arm, stop, a skipped sample tick or
// a rejected command, via a write state for a sample tick that stores
// (three channel writes through the single store port) and via a read state
// for a read (six words through that same port, read data registered);
// result and done are registered in the reply state. busy also rises while
// the job queue is full, so a burst of commands is taken at the memory
// side's pace. the user must write the decimation divider (cfg_valid/cfg_data)
// only while no command is outstanding; the core does not enforce this.
module multi_channel_trace_capture_core #(
  parameter int STORE_DEPTH = mctc_pkg::STORE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  // command side
  input  wire logic           start,
  input  wire mctc_pkg::cmd_t cmd,
  output logic                busy,
  // result side
  output logic                done,
  output mctc_pkg::result_t   result,
  // decimation divider write
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [15:0]    cfg_data
);

  // front to queue
  logic           push;
  mctc_pkg::job_t push_job;
  // queue to back
  mctc_pkg::job_t head;
  logic           q_empty;
  logic           q_full;
  logic           pop;
  // store swept clean
  logic           mem_ready;

  // divider register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // command decode, pointer and decimation state
  mctc_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .q_full    (q_full),
    .mem_ready (mem_ready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .push      (push),
    .job       (push_job)
  );

  // decouples command acceptance from memory work
  mctc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // store access and reply generation
  mctc_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head),
    .empty     (q_empty),
    .pop       (pop),
    .mem_ready (mem_ready),
    .done      (done),
    .result    (result)
  );

  // a result beat is never followed by another in the next cycle
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result beats");

  // nothing comes out while the store is still being swept
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    !mem_ready |-> !done)
    else $error("result beat during clearing pass");

  // a rejected command carries a short reply with empty payload
  a_reject_payload: assert property (@(posedge clk) disable iff (rst)
    done && !result.accepted |->
      result.reply_length == mctc_pkg::LEN_OTHER &&
      result.first_pointer == '0 && result.segment_words == '0 &&
      result.word_0 == '0 && result.word_5 == '0)
    else $error("rejected command with payload");

  // a read reply is always a handled command
  a_read_accepted: assert property (@(posedge clk) disable iff (rst)
    done && result.reply_length == mctc_pkg::LEN_READ |-> result.accepted)
    else $error("read reply marked rejected");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// testbench for the multi-channel trace capture core, self-checking against an inline predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH = mctc_pkg::STORE_DEPTH_DEF;
  // unknown command codes, all rejected by the core
  localparam logic [2:0] FUNC_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0] FUNC_UNKNOWN_LAST = 3'd7;
  // generous cycle budget: clearing sweep plus slowest legal run, several times over
  localparam int CYCLE_LIMIT = 400000;
  // quiet cycles after the last reply before the verdict
  localparam int TAIL_CYCLES = 24;

  logic clk;
  logic rst;
  logic start;
  mctc_pkg::cmd_t cmd;
  logic busy;
  logic done;
  mctc_pkg::result_t reply;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;

  multi_channel_trace_capture_core #(
    .STORE_DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .result(reply),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state: shadow of the sample store, channel pointers and decimation
  logic [15:0] trace_mem [DEPTH];
  int wr_ptr [3];
  int end_ptr [3];
  int seg_words;
  int skip_count;
  int divider;

  mctc_pkg::result_t replies_due [$];
  int mismatches;
  int cycle_count;
  // chance in percent that a command beat is followed by an idle burst
  int gap_pct;

  task automatic note_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_field(string what, int unsigned got, int unsigned want);
    if (got !== want) begin
      note_mismatch(what, got, want);
    end
  endtask

  function automatic logic [15:0] stored_word(int addr);
    if (addr < DEPTH) begin
      return trace_mem[addr];
    end
    return 16'h0000;
  endfunction

  // works out the reply of one accepted command and advances the shadow state
  function automatic mctc_pkg::result_t predict_reply(mctc_pkg::cmd_t c);
    mctc_pkg::result_t r;
    logic [15:0] smp [3];
    int start_addr;
    int k;
    r = '0;
    r.accepted = 1'b1;
    r.reply_length = mctc_pkg::LEN_OTHER;
    smp[0] = c.sample_a;
    smp[1] = c.sample_b;
    smp[2] = c.sample_c;
    case (c.func)
      mctc_pkg::FUNC_TICK: begin
        if (skip_count >= divider) begin
          skip_count = 0;
          for (k = 0; k < 3; k++) begin
            if (wr_ptr[k] < end_ptr[k] && wr_ptr[k] < DEPTH) begin
              trace_mem[wr_ptr[k]] = smp[k];
              wr_ptr[k]++;
            end
          end
        end else begin
          skip_count = (skip_count + 1) & 'hFFFF;
        end
      end
      mctc_pkg::FUNC_ARM: begin
        if (c.channel_count == 2'd0) begin
          r.accepted = 1'b0;
        end else begin
          seg_words = DEPTH / int'(c.channel_count);
          for (k = 0; k < 3; k++) begin
            if (k < int'(c.channel_count)) begin
              wr_ptr[k] = (k * DEPTH) / int'(c.channel_count);
              end_ptr[k] = ((k + 1) * DEPTH) / int'(c.channel_count);
            end else begin
              wr_ptr[k] = DEPTH;
            end
          end
        end
      end
      mctc_pkg::FUNC_QUERY: begin
        r.first_pointer = mctc_pkg::PTR_OUT_W'(wr_ptr[0]);
        r.segment_words = mctc_pkg::PTR_OUT_W'(seg_words);
      end
      mctc_pkg::FUNC_READ: begin
        // bank times segment plus offset, folded to 16 bits; the six words do not wrap
        start_addr = (int'(c.read_offset) + int'(c.read_bank) * seg_words) & 'hFFFF;
        r.word_0 = stored_word(start_addr);
        r.word_1 = stored_word(start_addr + 1);
        r.word_2 = stored_word(start_addr + 2);
        r.word_3 = stored_word(start_addr + 3);
        r.word_4 = stored_word(start_addr + 4);
        r.word_5 = stored_word(start_addr + 5);
        r.reply_length = mctc_pkg::LEN_READ;
      end
      mctc_pkg::FUNC_STOP: begin
        for (k = 0; k < 3; k++) begin
          wr_ptr[k] = DEPTH;
        end
      end
      default: begin
        r.accepted = 1'b0;
      end
    endcase
    return r;
  endfunction

  // command with every field random except the code
  function automatic mctc_pkg::cmd_t make_cmd(logic [2:0] f);
    mctc_pkg::cmd_t c;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    c = raw[$bits(mctc_pkg::cmd_t)-1:0];
    c.func = f;
    return c;
  endfunction

  // drives one command beat, waits for it to be taken, records its reply,
  // then maybe leaves start low for a burst
  task automatic send_cmd(mctc_pkg::cmd_t c);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    do begin
      @(posedge clk);
    end while (busy);
    replies_due.push_back(predict_reply(c));
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_arm(int n);
    mctc_pkg::cmd_t c;
    c = make_cmd(mctc_pkg::FUNC_ARM);
    c.channel_count = 2'(n);
    send_cmd(c);
  endtask

  task automatic send_tick(logic [15:0] a, logic [15:0] b, logic [15:0] s);
    mctc_pkg::cmd_t c;
    c = make_cmd(mctc_pkg::FUNC_TICK);
    c.sample_a = a;
    c.sample_b = b;
    c.sample_c = s;
    send_cmd(c);
  endtask

  task automatic send_read(logic [15:0] offset, logic [1:0] bank);
    mctc_pkg::cmd_t c;
    c = make_cmd(mctc_pkg::FUNC_READ);
    c.read_offset = offset;
    c.read_bank = bank;
    send_cmd(c);
  endtask

  // tick with three random samples
  task automatic send_random_tick;
    send_tick(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // lowers start and waits for every outstanding reply; every command has one
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (replies_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // decimation divider write, only while idle
  task automatic write_divider(logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    divider = int'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // reply checker: the core cannot be held off, so every done beat is taken here
  always @(posedge clk) begin
    mctc_pkg::result_t want;
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        note_mismatch("reply with nothing outstanding", 32'(reply.reply_length), 32'd0);
      end else begin
        want = replies_due.pop_front();
        compare_field("accepted", 32'(reply.accepted), 32'(want.accepted));
        compare_field("reply_length", 32'(reply.reply_length), 32'(want.reply_length));
        compare_field("first_pointer", 32'(reply.first_pointer), 32'(want.first_pointer));
        compare_field("segment_words", 32'(reply.segment_words), 32'(want.segment_words));
        compare_field("word_0", 32'(reply.word_0), 32'(want.word_0));
        compare_field("word_1", 32'(reply.word_1), 32'(want.word_1));
        compare_field("word_2", 32'(reply.word_2), 32'(want.word_2));
        compare_field("word_3", 32'(reply.word_3), 32'(want.word_3));
        compare_field("word_4", 32'(reply.word_4), 32'(want.word_4));
        compare_field("word_5", 32'(reply.word_5), 32'(want.word_5));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // fixed sequence: reset values, every command code, bank and boundary reads
  task automatic test_directed;
    logic [2:0] f;
    send_cmd(make_cmd(mctc_pkg::FUNC_QUERY));
    send_read(16'h0000, 2'd0);
    // tick while disarmed stores nothing
    send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_arm(0);
    send_arm(3);
    send_cmd(make_cmd(mctc_pkg::FUNC_QUERY));
    send_tick(16'hFFFF, 16'h0000, 16'hFFFF);
    send_tick(16'h0000, 16'hFFFF, 16'h0000);
    send_read(16'h0000, 2'd0);
    send_read(16'h0000, 2'd1);
    send_read(16'h0000, 2'd2);
    // bank 3 lands at the top of the store, last words read as zero
    send_read(16'h0000, 2'd3);
    // offset plus bank wraps around 16 bits
    send_read(16'hFFFF, 2'd3);
    // far past the store without wrapping
    send_read(16'hFFFF, 2'd0);
    send_read(16'd1020, 2'd0);
    for (f = FUNC_UNKNOWN_FIRST; f != mctc_pkg::FUNC_TICK; f++) begin
      send_cmd(make_cmd(f));
    end
    send_cmd(make_cmd(mctc_pkg::FUNC_STOP));
    send_tick(16'h1234, 16'h5678, 16'h9ABC);
    send_cmd(make_cmd(mctc_pkg::FUNC_QUERY));
    send_arm(1);
    send_cmd(make_cmd(mctc_pkg::FUNC_QUERY));
    send_arm(2);
    send_cmd(make_cmd(mctc_pkg::FUNC_QUERY));
    drain;
  endtask

  // divider settings including the largest, with ticks across each but the last, zero
  task automatic test_decimation;
    write_divider(16'd3);
    send_arm(2);
    repeat (12) send_random_tick;
    send_cmd(make_cmd(mctc_pkg::FUNC_QUERY));
    send_read(16'h0000, 2'd0);
    drain;
    write_divider(16'hFFFF);
    repeat (10) send_random_tick;
    send_cmd(make_cmd(mctc_pkg::FUNC_QUERY));
    drain;
    // counter now above the new divider, so the next tick stores
    write_divider(16'd1);
    repeat (6) send_random_tick;
    send_cmd(make_cmd(mctc_pkg::FUNC_QUERY));
    send_read(16'd512, 2'd0);
    drain;
    write_divider(16'd0);
  endtask

  // three channels run until every segment is full
  task automatic test_fill;
    send_arm(3);
    repeat (345) send_random_tick;
    send_cmd(make_cmd(mctc_pkg::FUNC_QUERY));
    send_read(16'd336, 2'd2);
    send_read(16'd338, 2'd0);
    send_read(16'd338, 2'd1);
    send_cmd(make_cmd(mctc_pkg::FUNC_STOP));
    drain;
  endtask

  // weighted mix of commands, mostly ticks and reads near the written data
  task automatic run_mix(int n);
    int pick;
    logic [15:0] offset;
    mctc_pkg::cmd_t c;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_random_tick;
      end else if (pick < 75) begin
        offset = 16'($urandom_range(0, seg_words + 8));
        if ($urandom_range(0, 7) == 0) begin
          offset = 16'($urandom);
        end else if ($urandom_range(0, 15) == 0) begin
          offset = 16'hFFFF - 16'($urandom_range(0, 7));
        end
        send_read(offset, 2'($urandom_range(0, 3)));
      end else if (pick < 83) begin
        send_cmd(make_cmd(mctc_pkg::FUNC_QUERY));
      end else if (pick < 87) begin
        send_cmd(make_cmd(mctc_pkg::FUNC_STOP));
      end else if (pick < 93) begin
        send_arm($urandom_range(0, 3));
      end else begin
        c = make_cmd(3'($urandom_range(FUNC_UNKNOWN_FIRST, FUNC_UNKNOWN_LAST)));
        send_cmd(c);
      end
    end
  endtask

  // phases with their own divider and idle pattern
  task automatic test_random;
    int phase;
    logic [15:0] setting;
    for (phase = 0; phase < 8; phase++) begin
      drain;
      case (phase)
        0: setting = 16'd0;
        1: setting = 16'd1;
        2: setting = 16'hFFFF;
        3: setting = 16'd2;
        4: setting = 16'($urandom_range(3, 9));
        5: setting = 16'($urandom);
        6: setting = 16'd0;
        default: setting = 16'($urandom_range(0, 4));
      endcase
      write_divider(setting);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 25;
        default: gap_pct = 50;
      endcase
      send_arm($urandom_range(1, 3));
      run_mix(160);
    end
    drain;
  endtask

  // last stretch back to back with no idling
  task automatic test_steady;
    gap_pct = 0;
    write_divider(16'd0);
    send_arm($urandom_range(1, 3));
    run_mix(120);
  endtask

  initial begin
    int k;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_data = 16'h0000;
    mismatches = 0;
    cycle_count = 0;
    gap_pct = 25;
    for (k = 0; k < DEPTH; k++) begin
      trace_mem[k] = 16'h0000;
    end
    for (k = 0; k < 3; k++) begin
      wr_ptr[k] = DEPTH;
      end_ptr[k] = DEPTH;
    end
    seg_words = DEPTH;
    skip_count = 0;
    divider = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_decimation();
    test_fill();
    test_random();
    test_steady();

    drain;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mctc_pkg.sv
rtl/core/mctc_front.sv
rtl/core/mctc_queue.sv
rtl/core/mctc_back.sv
rtl/core/multi_channel_trace_capture_core.sv
sim/tb_top.sv
